// ===== design/acpp_pkg.sv =====
// acpp_pkg: character classes, codes and per-byte scan functions
// for the ascii colour payload parser; no dependencies
package acpp_pkg;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    localparam int unsigned COMP_MAX   = 255;
    localparam int unsigned HEX_DIGITS = 6;
    localparam int unsigned DEC_BASE   = 10;
    localparam int unsigned DEC_NUMS   = 3;

    localparam logic [8:0] DEC_SAT = 9'(COMP_MAX + 1);

    // result kind codes
    localparam logic [1:0] KIND_REJECT = 2'd0;
    localparam logic [1:0] KIND_HEX    = 2'd1;
    localparam logic [1:0] KIND_DEC    = 2'd2;
    localparam logic [1:0] KIND_RAW    = 2'd3;

    // prefix detection phases
    localparam logic [1:0] PFX_NONE    = 2'd0;
    localparam logic [1:0] PFX_ZERO    = 2'd1;
    localparam logic [1:0] PFX_SETTLED = 2'd2;

    // decimal scanner phases
    localparam logic [1:0] DEC_GAP    = 2'd0;
    localparam logic [1:0] DEC_SIGN   = 2'd1;
    localparam logic [1:0] DEC_DIGITS = 2'd2;

    typedef struct packed {
        logic            failed;
        logic [1:0]      phase;
        logic [8:0]      value;
        logic            negative;
        logic [2:0]      count;
        logic [2:0][7:0] comps;
    } acpp_dec_t;

    typedef struct packed {
        logic        gap;
        logic        sep;
        logic        letter;
        logic [2:0]  count;
        logic [23:0] value;
    } acpp_hex_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] n;
        if (is_digit(c))
            n = c[3:0];
        else
            n = c[3:0] + 4'd9;  // 'a'/'A' have low nibble 1
        return n;
    endfunction

    function automatic acpp_dec_t dec_finish(input acpp_dec_t d);
        acpp_dec_t  s;
        logic [7:0] v;
        s = d;
        if (s.negative)
            v = 8'd0;
        else if (s.value > 9'(COMP_MAX))
            v = 8'(COMP_MAX);
        else
            v = s.value[7:0];
        if (s.count < 3'(DEC_NUMS))
            s.comps[s.count[1:0]] = v;
        if (s.count < 3'(DEC_NUMS + 1))
            s.count = s.count + 3'd1;
        if (s.count > 3'(DEC_NUMS))
            s.failed = 1'b1;
        s.phase    = DEC_GAP;
        s.value    = 9'd0;
        s.negative = 1'b0;
        return s;
    endfunction

    function automatic acpp_dec_t dec_step(input acpp_dec_t d, input logic [7:0] c);
        acpp_dec_t   s;
        logic        cont;
        logic [12:0] prod;
        s    = d;
        cont = 1'b1;
        prod = 13'(s.value) * 13'(DEC_BASE) + 13'(c[3:0]);
        if (!s.failed)
        begin
            if (s.phase == DEC_DIGITS)
            begin
                if (is_digit(c))
                begin
                    s.value = (prod > 13'(COMP_MAX)) ? DEC_SAT : prod[8:0];
                    cont    = 1'b0;
                end
                else
                begin
                    s = dec_finish(s);
                    if (s.failed)
                        cont = 1'b0;
                end
            end
            if (cont)
            begin
                if (s.phase == DEC_SIGN)
                begin
                    if (is_digit(c))
                    begin
                        s.value = 9'(c[3:0]);
                        s.phase = DEC_DIGITS;
                    end
                    else
                        s.failed = 1'b1;
                end
                else if (c == CH_COMMA || c == CH_SEMI || is_ws(c))
                    s.failed = s.failed;
                else if (c == CH_PLUS || c == CH_MINUS)
                begin
                    s.negative = (c == CH_MINUS);
                    s.value    = 9'd0;
                    s.phase    = DEC_SIGN;
                end
                else if (is_digit(c))
                begin
                    s.negative = 1'b0;
                    s.value    = 9'(c[3:0]);
                    s.phase    = DEC_DIGITS;
                end
                else
                    s.failed = 1'b1;
            end
        end
        return s;
    endfunction

    function automatic acpp_hex_t hex_step(input acpp_hex_t h, input logic [7:0] c);
        acpp_hex_t s;
        s = h;
        if (is_ws(c))
            s.gap = 1'b1;
        else
        begin
            if (s.gap)
            begin
                s.sep = 1'b1;
                s.gap = 1'b0;
            end
            if (c == CH_COMMA || c == CH_SEMI)
                s.sep = 1'b1;
            else if (is_digit(c) || is_hex_letter(c))
            begin
                if (!is_digit(c))
                    s.letter = 1'b1;
                if (s.count < 3'(HEX_DIGITS))
                begin
                    s.value = {s.value[19:0], hex_nibble(c)};
                    s.count = s.count + 3'd1;
                end
            end
        end
        return s;
    endfunction

endpackage

// ===== design/acpp_if.sv =====
// acpp_if: valid/ready channels of the colour payload parser
// byte channel in, colour result channel out; no dependencies
interface acpp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface acpp_color_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] result_kind;

    modport source (output valid, output red, output green, output blue,
                    output result_kind, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input result_kind, output ready);
endinterface

// ===== design/ascii_color_payload_parser_unit.sv =====
// ascii_color_payload_parser_unit: parses a hex, decimal or raw colour payload
// depends on acpp_pkg and the channel interfaces in acpp_if.sv
//
//  channel   dir  payload                          request
//  payload   in   byte_in[7:0], last_byte          one payload byte
//  color     out  red, green, blue, result_kind    one colour per payload
//
// one byte is taken every cycle; the scan state is updated at the byte's edge
// and the colour lands in the output register at the edge of the last byte
// a waiting colour stalls input only while color.ready is low
// rst_n clears scan state and the output valid flag asynchronously
module ascii_color_payload_parser_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    acpp_byte_if.sink            payload,
    acpp_color_if.source         color
);
    import acpp_pkg::*;

    logic [23:0] first_bytes_reg, first_bytes_next;
    logic [2:0]  byte_count_reg, byte_count_next;
    logic        text_started_reg, text_started_next;
    logic [1:0]  prefix_phase_reg, prefix_phase_next;
    logic        hex_preferred_reg, hex_preferred_next;
    acpp_hex_t   hex_reg, hex_next;
    acpp_dec_t   dec_reg, dec_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  red_reg, red_next;
    logic [7:0]  green_reg, green_next;
    logic [7:0]  blue_reg, blue_next;
    logic [1:0]  kind_reg, kind_next;

    logic        accept;

    assign payload.ready = !out_valid_reg || color.ready;
    assign accept        = payload.valid && payload.ready;

    always_comb
    begin
        logic [7:0] c;
        logic [23:0] fb;
        logic [2:0] bc;
        logic       ts;
        logic [1:0] pp;
        logic       hp;
        acpp_hex_t  h;
        acpp_dec_t  d;
        acpp_dec_t  df;
        logic [7:0] r, g, b;
        logic [1:0] k;

        c  = payload.byte_in;
        fb = first_bytes_reg;
        bc = byte_count_reg;
        ts = text_started_reg;
        pp = prefix_phase_reg;
        hp = hex_preferred_reg;
        h  = hex_reg;

        if (bc < 3'd3)
            fb[bc[1:0]*8 +: 8] = c;
        if (bc < 3'd4)
            bc = bc + 3'd1;

        d = dec_step(dec_reg, c);

        if (!ts)
        begin
            if (!is_ws(c))
            begin
                ts = 1'b1;
                if (c == CH_HASH)
                begin
                    hp = 1'b1;
                    pp = PFX_SETTLED;
                end
                else if (c == CH_ZERO)
                begin
                    pp = PFX_ZERO;
                    h  = hex_step(h, c);
                end
                else
                begin
                    pp = PFX_SETTLED;
                    h  = hex_step(h, c);
                end
            end
        end
        else if (pp == PFX_ZERO)
        begin
            pp = PFX_SETTLED;
            if (c == CH_LOW_X || c == CH_UP_X)
            begin
                // the leading zero was a prefix, not a digit
                hp      = 1'b1;
                h.count = 3'd0;
                h.value = 24'd0;
            end
            else
                h = hex_step(h, c);
        end
        else
            h = hex_step(h, c);

        // result as seen at the end of the payload
        df = (!d.failed && d.phase == DEC_DIGITS) ? dec_finish(d) : d;
        r  = 8'd0;
        g  = 8'd0;
        b  = 8'd0;
        k  = KIND_REJECT;
        if (ts)
        begin
            if (h.count >= 3'(HEX_DIGITS) && (hp || h.letter || !h.sep))
            begin
                r = h.value[23:16];
                g = h.value[15:8];
                b = h.value[7:0];
                k = KIND_HEX;
            end
            else if (!hp && !df.failed && df.phase == DEC_GAP
                     && df.count == 3'(DEC_NUMS))
            begin
                r = df.comps[0];
                g = df.comps[1];
                b = df.comps[2];
                k = KIND_DEC;
            end
        end
        if (k == KIND_REJECT && bc == 3'd3)
        begin
            r = fb[7:0];
            g = fb[15:8];
            b = fb[23:16];
            k = KIND_RAW;
        end

        first_bytes_next   = first_bytes_reg;
        byte_count_next    = byte_count_reg;
        text_started_next  = text_started_reg;
        prefix_phase_next  = prefix_phase_reg;
        hex_preferred_next = hex_preferred_reg;
        hex_next           = hex_reg;
        dec_next           = dec_reg;
        out_valid_next     = out_valid_reg && !color.ready;
        red_next           = red_reg;
        green_next         = green_reg;
        blue_next          = blue_reg;
        kind_next          = kind_reg;

        if (accept)
        begin
            if (payload.last_byte)
            begin
                first_bytes_next   = 24'd0;
                byte_count_next    = 3'd0;
                text_started_next  = 1'b0;
                prefix_phase_next  = PFX_NONE;
                hex_preferred_next = 1'b0;
                hex_next           = '0;
                dec_next           = '0;
                out_valid_next     = 1'b1;
                red_next           = r;
                green_next         = g;
                blue_next          = b;
                kind_next          = k;
            end
            else
            begin
                first_bytes_next   = fb;
                byte_count_next    = bc;
                text_started_next  = ts;
                prefix_phase_next  = pp;
                hex_preferred_next = hp;
                hex_next           = h;
                dec_next           = d;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_bytes_reg   <= 24'd0;
            byte_count_reg    <= 3'd0;
            text_started_reg  <= 1'b0;
            prefix_phase_reg  <= PFX_NONE;
            hex_preferred_reg <= 1'b0;
            hex_reg           <= '0;
            dec_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            first_bytes_reg   <= first_bytes_next;
            byte_count_reg    <= byte_count_next;
            text_started_reg  <= text_started_next;
            prefix_phase_reg  <= prefix_phase_next;
            hex_preferred_reg <= hex_preferred_next;
            hex_reg           <= hex_next;
            dec_reg           <= dec_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        kind_reg  <= kind_next;
    end

    assign color.valid       = out_valid_reg;
    assign color.red         = red_reg;
    assign color.green       = green_reg;
    assign color.blue        = blue_reg;
    assign color.result_kind = kind_reg;

endmodule
